FILE: hdl/ccp_pkg.sv
// Shared constants for the CRC codeword packer.
package ccp_pkg;

  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int HDR_MAX  = 15;   // header byte plus up to seven pad bits
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int POLY_W   = 17;
  localparam int GLEN_W   = 5;
  localparam int MLEN_W   = 16;

  localparam logic [1:0] REG_POLY = 2'd0;
  localparam logic [1:0] REG_GLEN = 2'd1;
  localparam logic [1:0] REG_DSEL = 2'd2;
  localparam logic [1:0] REG_MLEN = 2'd3;

  localparam logic [POLY_W-1:0] POLY_RST = 17'd11;
  localparam logic [GLEN_W-1:0] GLEN_RST = 5'd4;
  localparam logic              DSEL_RST = 1'b1;
  localparam logic [MLEN_W-1:0] MLEN_RST = 16'd1;

endpackage

FILE: hdl/ccp_front.sv
// Front end: takes message bytes, computes codewords and header, builds a bit record.
module ccp_front import ccp_pkg::*; #(
  parameter int MAX_GEN_LEN = 17,
  parameter int RECW        = 55,
  parameter int RLW         = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [POLY_W-1:0] gen_poly_i,
  input  logic [GLEN_W-1:0] gen_len_i,
  input  logic              dsel_i,
  input  logic [MLEN_W-1:0] mlen_i,
  input  logic              in_valid_i,
  input  logic [BYTE_W-1:0] in_data_i,
  input  logic              q_ready_i,
  output logic              in_ready_o,
  output logic              rec_valid_o,
  output logic [RECW-1:0]   rec_bits_o,
  output logic [RLW-1:0]    rec_len_o,
  output logic              rec_end_o
);

  localparam int MAXR = MAX_GEN_LEN - 1;
  localparam int CWW  = 2 * (NIB_W + MAXR);
  localparam int LW   = $clog2(MAX_GEN_LEN + 1);
  localparam int PW   = (MAXR > POLY_W) ? MAXR : POLY_W;

  logic              hdr_sent_q, hdr_sent_d;
  logic [MLEN_W-1:0] seen_q, seen_d;

  logic [LW-1:0]     len, r;
  logic [7:0]        r8;
  logic [PW-1:0]     poly_x, pmask;
  logic [MAXR-1:0]   pl;
  logic [MAXR-1:0]   rem8, remh, reml;
  logic              fb;
  logic [CWW-1:0]    cw, cw_hi, cw_lo;
  logic [RLW-1:0]    cw_len, hdr_len;
  logic [RECW-1:0]   hdr_al;
  logic [2:0]        mlen3, per3, pad;
  logic [5:0]        prod;
  logic [MLEN_W-1:0] mlen, seen_nx;
  logic              msg_end, accept;

  always_comb begin
    if (gen_len_i < GLEN_W'(2)) begin
      len = LW'(2);
    end else if (int'(gen_len_i) > MAX_GEN_LEN) begin
      len = LW'(MAX_GEN_LEN);
    end else begin
      len = LW'(gen_len_i);
    end
    r  = len - LW'(1);
    r8 = 8'(r);

    poly_x = PW'(gen_poly_i);
    pmask  = (PW'(1) << r) - PW'(1);
    pl     = MAXR'(poly_x & pmask) << (LW'(MAXR) - r);

    rem8 = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb   = in_data_i[i] ^ rem8[MAXR-1];
      rem8 = (rem8 << 1) ^ (fb ? pl : '0);
    end
    remh = '0;
    reml = '0;
    for (int i = NIB_W - 1; i >= 0; i--) begin
      fb   = in_data_i[NIB_W + i] ^ remh[MAXR-1];
      remh = (remh << 1) ^ (fb ? pl : '0);
      fb   = in_data_i[i] ^ reml[MAXR-1];
      reml = (reml << 1) ^ (fb ? pl : '0);
    end

    cw_hi = {in_data_i[BYTE_W-1:NIB_W], remh, (NIB_W + MAXR)'(0)};
    cw_lo = {in_data_i[NIB_W-1:0], reml, (NIB_W + MAXR)'(0)};
    if (dsel_i) begin
      cw     = {in_data_i, rem8, MAXR'(0)};
      cw_len = RLW'(BYTE_W) + RLW'(r);
    end else begin
      cw     = cw_hi | (cw_lo >> (RLW'(NIB_W) + RLW'(r)));
      cw_len = RLW'(BYTE_W) + RLW'(r) + RLW'(r);
    end

    mlen3 = (mlen_i == '0) ? 3'd1 : mlen_i[2:0];
    per3  = dsel_i ? r8[2:0] : {r8[1:0], 1'b0};
    prod  = 6'(mlen3 * per3);
    pad   = 3'(3'd0 - prod[2:0]);
    if (!hdr_sent_q) begin
      hdr_al  = {5'd0, pad, (RECW - BYTE_W)'(0)};
      hdr_len = RLW'(BYTE_W) + RLW'(pad);
    end else begin
      hdr_al  = '0;
      hdr_len = '0;
    end

    mlen    = (mlen_i == '0) ? MLEN_W'(1) : mlen_i;
    seen_nx = seen_q + MLEN_W'(1);
    msg_end = (seen_nx >= mlen) || (seen_nx == '0);
  end

  assign in_ready_o  = q_ready_i;
  assign accept      = in_valid_i && q_ready_i;
  assign rec_valid_o = in_valid_i;
  assign rec_bits_o  = hdr_al | ({cw, HDR_MAX'(0)} >> hdr_len);
  assign rec_len_o   = hdr_len + cw_len;
  assign rec_end_o   = msg_end;

  always_comb begin
    hdr_sent_d = hdr_sent_q;
    seen_d     = seen_q;
    if (accept) begin
      hdr_sent_d = !msg_end;
      seen_d     = msg_end ? '0 : seen_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_sent_q <= 1'b0;
      seen_q     <= '0;
    end else begin
      hdr_sent_q <= hdr_sent_d;
      seen_q     <= seen_d;
    end
  end

endmodule

FILE: hdl/ccp_queue.sv
// Two-entry record queue between front end and packer.
module ccp_queue import ccp_pkg::*; #(
  parameter int WIDTH = 62
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o    = (cnt_q != 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rp_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q ^ do_push;
    rp_d  = rp_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/ccp_back.sv
// Back end: merges bit records, sends one packed byte per cycle if not stalled.
module ccp_back import ccp_pkg::*; #(
  parameter int RECW = 55,
  parameter int RLW  = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  logic [RECW-1:0]   q_bits_i,
  input  logic [RLW-1:0]    q_len_i,
  input  logic              q_end_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o,
  output logic              out_end_o
);

  localparam int BUFW = RECW + 7;
  localparam int CW   = $clog2(BUFW + 1);

  logic [BUFW-1:0]   buf_q, buf_d;
  logic [CW-1:0]     cnt_q, cnt_d, rem;
  logic              end_q, end_d;
  logic              ov_q, ov_d, ol_q, ol_d, oe_q, oe_d;
  logic [BYTE_W-1:0] ob_q, ob_d;
  logic              emit_full, have, can_adv, last, pop;

  always_comb begin
    emit_full = (cnt_q >= CW'(BYTE_W));
    have      = emit_full || (end_q && (cnt_q != '0));
    can_adv   = !ov_q || out_ready_i;
    rem       = emit_full ? (cnt_q - CW'(BYTE_W)) : '0;
    last      = (rem < CW'(BYTE_W)) && !(end_q && (rem != '0));
    pop       = !have && q_valid_i;

    buf_d = buf_q;
    cnt_d = cnt_q;
    end_d = end_q;
    if (have && can_adv) begin
      buf_d = buf_q << BYTE_W;
      cnt_d = rem;
      end_d = end_q && !last;
    end else if (pop) begin
      buf_d = buf_q | ({q_bits_i, 7'd0} >> cnt_q);
      cnt_d = cnt_q + CW'(q_len_i);
      end_d = q_end_i;
    end

    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    oe_d = oe_q;
    if (can_adv) begin
      ov_d = have;
      ob_d = buf_q[BUFW-1 -: BYTE_W];
      ol_d = last;
      oe_d = last && end_q;
    end
  end

  assign q_pop_o     = pop;
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;
  assign out_end_o   = oe_q;

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
    oe_q <= oe_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      end_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      end_q <= end_d;
      ov_q  <= ov_d;
    end
  end

endmodule

FILE: hdl/crc_codeword_packer.sv
// Top level of the CRC codeword packer: register port, front end, queue, packer.
// Path: an accepted byte passes the queue, the packer buffer and the output register to m_axis_tdata.
// Throughput: one output byte per cycle unless m_axis_tready stalls it or the packer
// loads a record, which it does only when it has no byte to send; input waits for queue room.
// Reset: registers return to their defaults, the stream state and queue are cleared.
module crc_codeword_packer import ccp_pkg::*; #(
  parameter int MAX_GEN_LEN = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast,   // run_last
  output logic              m_axis_tuser    // [0] message_end
);

  localparam int MAXR = MAX_GEN_LEN - 1;
  localparam int RECW = HDR_MAX + 2 * (NIB_W + MAXR);
  localparam int RLW  = $clog2(RECW + 1);
  localparam int QW   = RECW + RLW + 1;

  logic [POLY_W-1:0] poly_q;
  logic [GLEN_W-1:0] glen_q;
  logic              dsel_q;
  logic [MLEN_W-1:0] mlen_q;
  logic              wr;

  logic              rec_valid, q_ready, q_valid, q_pop, rec_end;
  logic [RECW-1:0]   rec_bits;
  logic [RLW-1:0]    rec_len;
  logic [QW-1:0]     q_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RST;
      glen_q <= GLEN_RST;
      dsel_q <= DSEL_RST;
      mlen_q <= MLEN_RST;
    end else if (wr) begin
      case (paddr[3:2])
        REG_POLY: poly_q <= pwdata[POLY_W-1:0];
        REG_GLEN: glen_q <= pwdata[GLEN_W-1:0];
        REG_DSEL: dsel_q <= pwdata[0];
        REG_MLEN: mlen_q <= pwdata[MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POLY: prdata = APB_DW'(poly_q);
      REG_GLEN: prdata = APB_DW'(glen_q);
      REG_DSEL: prdata = APB_DW'(dsel_q);
      REG_MLEN: prdata = APB_DW'(mlen_q);
      default:  prdata = '0;
    endcase
  end

  ccp_front #(
    .MAX_GEN_LEN(MAX_GEN_LEN),
    .RECW       (RECW),
    .RLW        (RLW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gen_poly_i (poly_q),
    .gen_len_i  (glen_q),
    .dsel_i     (dsel_q),
    .mlen_i     (mlen_q),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .q_ready_i  (q_ready),
    .in_ready_o (s_axis_tready),
    .rec_valid_o(rec_valid),
    .rec_bits_o (rec_bits),
    .rec_len_o  (rec_len),
    .rec_end_o  (rec_end)
  );

  ccp_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rec_valid),
    .push_data_i({rec_end, rec_len, rec_bits}),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_out)
  );

  ccp_back #(
    .RECW(RECW),
    .RLW (RLW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_bits_i   (q_out[RECW-1:0]),
    .q_len_i    (q_out[RECW +: RLW]),
    .q_end_i    (q_out[QW-1]),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_end_o  (m_axis_tuser)
  );

endmodule
